@@ rtl/rc4_pkg.sv @@
// Shared constants, types and a helper function for the RC4 stream cipher.
// No dependencies; used by rc4_stream_cipher.
`default_nettype none

package rc4_pkg;

    localparam int KEY_BYTES  = 40;
    localparam int KEY_WORDS  = 5;
    localparam int WORD_W     = 64;
    localparam int PERM_DEPTH = 256;
    localparam int BYTE_W     = 8;
    localparam int KIDX_W     = 6;
    localparam int WIDX_W     = 3;

    localparam logic OP_INIT  = 1'b0;
    localparam logic OP_CRYPT = 1'b1;

    typedef logic [WORD_W-1:0] t_key [KEY_WORDS];

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FILL,
        ST_KS_RD,
        ST_KS_ACC,
        ST_KS_WR1,
        ST_KS_WR2,
        ST_CR_RDJ,
        ST_CR_SW,
        ST_CR_OUT,
        ST_EMIT
    } t_state;

    // Key byte k lives in word k/8 at bit 8*(k%8); bytes past the last word read as zero.
    function automatic logic [BYTE_W-1:0] key_byte(input t_key key,
                                                   input logic [KIDX_W-1:0] kidx);
        logic [WIDX_W-1:0] w;
        logic [WORD_W-1:0] word;
        logic [BYTE_W-1:0] res;
        w    = kidx[KIDX_W-1:3];
        word = '0;
        if (w < WIDX_W'(KEY_WORDS)) begin
            word = key[w];
        end
        res = word[8*kidx[2:0] +: BYTE_W];
        return res;
    endfunction

endpackage

`default_nettype wire

@@ rtl/rc4_stream_cipher.sv @@
// RC4 stream cipher engine: top level with the permutation memory and its sequencer.
// Depends on rc4_pkg for constants, the state type and the key byte selector.
//
// Usage:
//   The key is five 64-bit words written on the configuration channel (i_cfg_valid,
//   o_cfg_ready, i_cfg_index 0 to 4, i_cfg_data); other indexes are accepted and ignored.
//   The key is read only while an init transaction runs, so a new key takes effect
//   at the next init.
//   Each slave transaction carries tuser = op and tdata = data byte. Op 0 (init) runs
//   the key schedule and gives no result; op 1 (crypt) gives one master transaction
//   with tdata = data XOR keystream and tuser = 0. A crypt before any init gives
//   tdata 0 and tuser 1, loaded into the output register from the emit state.
//   Timing: one item at a time. Init passes through the acceptance, a pass loading
//   the identity permutation, then the read, read, write, write of each swap. A crypt
//   item passes through its acceptance, the read of S[j], the first swap write with
//   the keystream read, the second swap write and the output load; its result
//   appears and o_s_tready rises again after the output load. A result waits in the
//   output register while the receiver stalls; the next item may be accepted
//   meanwhile, and its own result is held until the register is free.
//   Reset (synchronous, active low) clears the key, both indices, the schedule-done
//   flag and the output valid; the permutation memory is rewritten by the next init.
`default_nettype none

module rc4_stream_cipher (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Configuration write channel
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [63:0] i_cfg_data,
    // Slave stream
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [7:0]  i_s_tdata,   // [7:0] data_in
    input  wire logic        i_s_tuser,   // [0] op (0 init, 1 crypt)
    // Master stream
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [7:0]       o_m_tdata,   // [7:0] data_out
    output logic             o_m_tuser    // [0] not_ready
);

    localparam int BW = rc4_pkg::BYTE_W;

    // The permutation memory: one write port, one read port, registered read data.
    logic [BW-1:0] r_perm [rc4_pkg::PERM_DEPTH];
    logic [BW-1:0] r_rdata;
    logic          mem_we;
    logic [BW-1:0] mem_wa;
    logic [BW-1:0] mem_wd;
    logic [BW-1:0] mem_ra;

    rc4_pkg::t_state r_state, n_state;
    rc4_pkg::t_key   r_key;

    logic [BW-1:0]             r_n, n_n;
    logic [rc4_pkg::KIDX_W-1:0] r_kidx, n_kidx;
    logic [BW-1:0]             r_acc, n_acc;
    logic [BW-1:0]             r_i, n_i;
    logic [BW-1:0]             r_j, n_j;
    logic [BW-1:0]             r_si, n_si;
    logic [BW-1:0]             r_sj, n_sj;
    logic                      r_fwd_i, n_fwd_i;
    logic                      r_fwd_j, n_fwd_j;
    logic                      r_done, n_done;
    logic [BW-1:0]             r_res, n_res;
    logic                      r_err, n_err;

    logic                      r_m_valid;
    logic [BW-1:0]             r_m_data;
    logic                      r_m_err;
    logic                      out_load;

    logic [BW-1:0]             acc_sum;
    logic [BW-1:0]             t_idx;
    logic [BW-1:0]             ks;

    assign o_cfg_ready = 1'b1;
    assign o_s_tready  = (r_state == rc4_pkg::ST_IDLE);
    assign o_m_tvalid  = r_m_valid;
    assign o_m_tdata   = r_m_data;
    assign o_m_tuser   = r_m_err;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_perm[mem_wa] <= mem_wd;
        end
        r_rdata <= r_perm[mem_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key <= '{default: '0};
        end else if (i_cfg_valid && (i_cfg_index < 3'(rc4_pkg::KEY_WORDS))) begin
            r_key[i_cfg_index] <= i_cfg_data;
        end
    end

    // Running key-schedule accumulator and the index of the final keystream read.
    assign acc_sum = r_acc + r_rdata + rc4_pkg::key_byte(r_key, r_kidx);
    assign t_idx   = r_si + r_rdata;
    // The final read overlaps the first swap write; the swapped values are forwarded.
    assign ks      = r_fwd_j ? r_si : (r_fwd_i ? r_sj : r_rdata);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rc4_pkg::ST_IDLE;
            r_i     <= '0;
            r_j     <= '0;
            r_done  <= 1'b0;
            r_n     <= '0;
            r_kidx  <= '0;
            r_acc   <= '0;
        end else begin
            r_state <= n_state;
            r_i     <= n_i;
            r_j     <= n_j;
            r_done  <= n_done;
            r_n     <= n_n;
            r_kidx  <= n_kidx;
            r_acc   <= n_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        r_si    <= n_si;
        r_sj    <= n_sj;
        r_fwd_i <= n_fwd_i;
        r_fwd_j <= n_fwd_j;
        r_res   <= n_res;
        r_err   <= n_err;
    end

    always_comb begin
        n_state  = r_state;
        n_n      = r_n;
        n_kidx   = r_kidx;
        n_acc    = r_acc;
        n_i      = r_i;
        n_j      = r_j;
        n_si     = r_si;
        n_sj     = r_sj;
        n_fwd_i  = r_fwd_i;
        n_fwd_j  = r_fwd_j;
        n_done   = r_done;
        n_res    = r_res;
        n_err    = r_err;
        mem_we   = 1'b0;
        mem_wa   = r_n;
        mem_wd   = r_n;
        mem_ra   = r_n;
        out_load = 1'b0;

        case (r_state)
            rc4_pkg::ST_IDLE: begin
                if (i_s_tvalid) begin
                    if (i_s_tuser == rc4_pkg::OP_INIT) begin
                        n_n     = '0;
                        n_state = rc4_pkg::ST_FILL;
                    end else if (!r_done) begin
                        n_res   = '0;
                        n_err   = 1'b1;
                        n_state = rc4_pkg::ST_EMIT;
                    end else begin
                        n_i     = r_i + 8'd1;
                        mem_ra  = r_i + 8'd1;
                        n_res   = i_s_tdata;
                        n_err   = 1'b0;
                        n_state = rc4_pkg::ST_CR_RDJ;
                    end
                end
            end
            rc4_pkg::ST_FILL: begin
                mem_we = 1'b1;
                n_n    = r_n + 8'd1;
                if (r_n == 8'hFF) begin
                    n_acc   = '0;
                    n_kidx  = '0;
                    n_state = rc4_pkg::ST_KS_RD;
                end
            end
            rc4_pkg::ST_KS_RD: begin
                n_state = rc4_pkg::ST_KS_ACC;
            end
            rc4_pkg::ST_KS_ACC: begin
                n_si    = r_rdata;
                n_acc   = acc_sum;
                mem_ra  = acc_sum;
                n_state = rc4_pkg::ST_KS_WR1;
            end
            rc4_pkg::ST_KS_WR1: begin
                mem_we  = 1'b1;
                mem_wd  = r_rdata;
                n_state = rc4_pkg::ST_KS_WR2;
            end
            rc4_pkg::ST_KS_WR2: begin
                mem_we = 1'b1;
                mem_wa = r_acc;
                mem_wd = r_si;
                n_kidx = (r_kidx == rc4_pkg::KIDX_W'(rc4_pkg::KEY_BYTES - 1)) ? '0
                                                                               : r_kidx + 6'd1;
                n_n    = r_n + 8'd1;
                if (r_n == 8'hFF) begin
                    n_i     = '0;
                    n_j     = '0;
                    n_done  = 1'b1;
                    n_state = rc4_pkg::ST_IDLE;
                end else begin
                    n_state = rc4_pkg::ST_KS_RD;
                end
            end
            rc4_pkg::ST_CR_RDJ: begin
                n_si    = r_rdata;
                n_j     = r_j + r_rdata;
                mem_ra  = r_j + r_rdata;
                n_state = rc4_pkg::ST_CR_SW;
            end
            rc4_pkg::ST_CR_SW: begin
                n_sj    = r_rdata;
                mem_we  = 1'b1;
                mem_wa  = r_i;
                mem_wd  = r_rdata;
                mem_ra  = t_idx;
                n_fwd_i = (t_idx == r_i);
                n_fwd_j = (t_idx == r_j);
                n_state = rc4_pkg::ST_CR_OUT;
            end
            rc4_pkg::ST_CR_OUT: begin
                mem_we  = 1'b1;
                mem_wa  = r_j;
                mem_wd  = r_si;
                n_res   = r_res ^ ks;
                n_state = rc4_pkg::ST_EMIT;
            end
            rc4_pkg::ST_EMIT: begin
                if (!r_m_valid || i_m_tready) begin
                    out_load = 1'b1;
                    n_state  = rc4_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = rc4_pkg::ST_IDLE;
            end
        endcase
    end

    // Output register: holds a result until the receiver takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (out_load) begin
            r_m_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_m_data <= r_res;
            r_m_err  <= r_err;
        end
    end

    // An error result always carries a zero data byte.
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser) |-> (o_m_tdata == 8'd0))
        else $error("error result with nonzero data");

    // Once the key schedule has completed, the engine stays keyed until reset.
    a_done_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> r_done)
        else $error("schedule-done flag dropped");

    // The permutation memory is never written while the engine is idle.
    a_no_idle_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rc4_pkg::ST_IDLE) |-> !mem_we)
        else $error("memory write while idle");

    // A result is loaded only when the output register is free or being emptied.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |-> (!r_m_valid || i_m_tready))
        else $error("output register overwritten");

endmodule

`default_nettype wire
